// ===== rtl/tdc_pkg.sv =====
// tdc_pkg: shared widths for the trial-division composite test
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package tdc_pkg;

	localparam int VALUE_WIDTH = 32;
	// odd magnitude stays below 2^(VALUE_WIDTH-1), so divisor reaches about 2^(VALUE_WIDTH/2)
	localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
	localparam int SQ_WIDTH    = VALUE_WIDTH + 1;
	localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [VALUE_WIDTH-1:0]        mag_t;
	typedef logic [DIV_WIDTH-1:0]          div_t;
	typedef logic [SQ_WIDTH-1:0]           sq_t;
	typedef logic [CNT_WIDTH-1:0]          cnt_t;

endpackage

`default_nettype wire

// ===== rtl/tdc_if.sv =====
// tdc_value_if and tdc_flag_if: valid/ready channels of the composite test
// depends on tdc_pkg
`default_nettype none

interface tdc_value_if;
	import tdc_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface tdc_flag_if;
	logic valid;
	logic ready;
	logic is_composite;

	modport source (output valid, output is_composite, input ready);
	modport sink   (input valid, input is_composite, output ready);
endinterface

`default_nettype wire

// ===== rtl/trial_division_composite_test.sv =====
// Trial-division composite test: takes a signed value, answers 1 when its magnitude is
// composite, 0 for primes and for magnitudes 0, 1 and 2. Sign is dropped, even magnitudes
// above 2 go straight to the finish state. Odd magnitudes are divided by 3, 5, 7, ...
// while d*d <= m; each trial is a bound check, then a restoring remainder over VALUE_WIDTH
// bits in one shared subtract-compare unit, then a remainder test. One item is in work at
// a time; the input is not ready until the flag has been moved into the output register,
// which holds it until taken.
// depends on tdc_pkg and tdc_if
`default_nettype none

module trial_division_composite_test (
	input  wire logic clk,
	input  wire logic arst_n,
	tdc_value_if.sink sample,
	tdc_flag_if.source result
);
	import tdc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_EVAL,
		ST_FINISH
	} state_t;

	state_t state_q;
	mag_t   mag_q;
	mag_t   shift_q;
	div_t   div_q;
	div_t   rem_q;
	sq_t    sq_q;
	cnt_t   cnt_q;
	logic   flag_q;
	logic   out_valid_q;
	logic   out_flag_q;

	mag_t                 in_mag;
	logic [DIV_WIDTH:0]   trial;
	logic [DIV_WIDTH:0]   trial_diff;
	logic                 trial_ge;
	sq_t                  sq_next;

	assign in_mag     = sample.value[VALUE_WIDTH-1] ? mag_t'(-sample.value) : mag_t'(sample.value);
	assign trial      = {rem_q, shift_q[VALUE_WIDTH-1]};
	assign trial_diff = trial - {1'b0, div_q};
	assign trial_ge   = trial >= {1'b0, div_q};
	assign sq_next    = sq_q + sq_t'({div_q, 2'b00}) + sq_t'(4);

	assign sample.ready        = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.is_composite = out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mag_q       <= '0;
			shift_q     <= '0;
			div_q       <= div_t'(3);
			rem_q       <= '0;
			sq_q        <= sq_t'(9);
			cnt_q       <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_flag_q  <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						mag_q <= in_mag;
						div_q <= div_t'(3);
						sq_q  <= sq_t'(9);
						rem_q <= '0;
						if (in_mag <= mag_t'(2)) begin
							flag_q  <= 1'b0;
							state_q <= ST_FINISH;
						end else if (!in_mag[0]) begin
							flag_q  <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (sq_q > {1'b0, mag_q}) begin
						flag_q  <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						rem_q   <= '0;
						shift_q <= mag_q;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q   <= trial_ge ? trial_diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
					shift_q <= shift_q << 1;
					cnt_q   <= cnt_q + cnt_t'(1);
					if (cnt_q == cnt_t'(VALUE_WIDTH - 1)) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (rem_q == '0) begin
						flag_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						div_q   <= div_q + div_t'(2);
						sq_q    <= sq_next;
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || result.ready) begin
						out_flag_q  <= flag_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// trial divisors are always odd
	assert property (@(posedge clk) disable iff (!arst_n) div_q[0])
		else $error("even trial divisor");

	// partial remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_EVAL) |-> (rem_q < div_q))
		else $error("partial remainder not reduced");

	// an accepted beat starts work
	assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> (state_q != ST_IDLE))
		else $error("accepted beat dropped");

	// a result only appears at the end of an item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result beat without finished item");

endmodule

`default_nettype wire

// ===== sim/tdc_flag_checker.sv =====
// tdc_flag_checker: watches both channels of the composite test, predicts each flag
// and compares it with the flag the block returns; reports a failure count to the top
// depends on tdc_pkg and tdc_if
module tdc_flag_checker (
	input  logic clk,
	input  logic arst_n,
	tdc_value_if sample,
	tdc_flag_if  result,
	output int   errors,
	output int   pending,
	output int   checked,
	output int   composites
);
	timeunit 1ns;
	timeprecision 1ps;
	import tdc_pkg::*;

	logic   expected_flags [$];
	value_t tested_values [$];

	function automatic logic composite_of(value_t v);
		mag_t mag;
		mag_t div;
		mag = v[VALUE_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
		if (mag <= 2)
			return 1'b0;
		if (!mag[0])
			return 1'b1;
		div = 3;
		while (div <= mag / div) begin
			if (mag % div == 0)
				return 1'b1;
			div += 2;
		end
		return 1'b0;
	endfunction

	initial begin
		errors     = 0;
		pending    = 0;
		checked    = 0;
		composites = 0;
	end

	always @(posedge clk) begin
		logic   flag;
		value_t tested;
		if (arst_n) begin
			if (sample.valid && sample.ready) begin
				expected_flags.push_back(composite_of(sample.value));
				tested_values.push_back(sample.value);
			end
			if (result.valid && result.ready) begin
				checked++;
				if (result.is_composite)
					composites++;
				if (expected_flags.size() == 0) begin
					errors++;
					$display("%0t: unexpected is_composite beat: expected none, got %0b",
						$time, result.is_composite);
				end else begin
					flag   = expected_flags.pop_front();
					tested = tested_values.pop_front();
					if (result.is_composite !== flag) begin
						errors++;
						$display("%0t: is_composite for %0d: expected %0b, got %0b",
							$time, tested, flag, result.is_composite);
					end
				end
			end
			pending = expected_flags.size();
		end
	end

endmodule

// ===== sim/trial_division_composite_test_tb.sv =====
// trial_division_composite_test_tb: drives directed and random values into the
// composite test with random gaps on both channels and gives the verdict
// depends on tdc_pkg, tdc_if, the block and tdc_flag_checker
module trial_division_composite_test_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tdc_pkg::*;

	localparam int N_RANDOM = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic burst;
	int   errors;
	int   pending;
	int   checked;
	int   composites;
	int   stall;

	// edge values, squares of primes, a large prime and the most negative value
	value_t directed_values [24] = '{
		32'sd0, 32'sd1, 32'sd2, -32'sd1, -32'sd2, 32'sd3, -32'sd3, 32'sd4,
		32'sd5, 32'sd8, 32'sd9, 32'sd15, 32'sd25, 32'sd49, 32'sd121, 32'sd7919,
		32'sd65537, 32'sd1022117, 32'sd1042441, 32'sd2147483647, -32'sd2147483645,
		32'sd2147483646, -32'sd2147483646, 32'sh8000_0000
	};

	tdc_value_if sample_ch ();
	tdc_flag_if  result_ch ();

	trial_division_composite_test u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	tdc_flag_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_ch),
		.result     (result_ch),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked),
		.composites (composites)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// mostly small magnitudes; full-width ones are even or multiples of three
	function automatic value_t random_value();
		int   r;
		mag_t mag;
		r = $urandom_range(0, 99);
		if (r < 40)
			mag = $urandom_range(0, 4095);
		else if (r < 55)
			mag = $urandom_range(0, 1 << 20);
		else if (r < 80)
			mag = mag_t'($urandom) & 32'h7FFF_FFFE;
		else
			mag = 3 * mag_t'($urandom_range(1, 715827882));
		return $urandom_range(0, 1) ? value_t'(-mag) : value_t'(mag);
	endfunction

	task automatic send_value(input value_t v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.value <= v;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
		@(negedge clk);
	endtask

	initial begin
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
			@(negedge clk);
		end
	end

	initial begin
		arst_n          = 1'b0;
		burst           = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.value = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (directed_values[i])
			send_value(directed_values[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			burst = (i >= 60 && i < 80);
			send_value(random_value());
		end
		sample_ch.valid <= 1'b0;
		burst = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		$display("tested %0d directed and %0d random values with random gaps on both sides",
			$size(directed_values), N_RANDOM);
		$display("%0d flags compared, %0d of them composite, %0d mismatches",
			checked, composites, errors);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#(200_000_000);
		$display("timed out with %0d flags outstanding", pending);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tdc_pkg.sv
rtl/tdc_if.sv
rtl/trial_division_composite_test.sv
sim/tdc_flag_checker.sv
sim/trial_division_composite_test_tb.sv
